// File: rtl/gau_pkg.sv
// Gaussian activation unit: shared types and constants.
// Used by gau_fwd, gau_bwd and gaussian_activation_unit_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gau_pkg;

  localparam int FRAC_BITS_DEF      = 16;
  localparam int EXP_TABLE_BITS_DEF = 6;

  // compute stages ahead of the output register
  localparam int PIPE_STAGES = 8;

  localparam logic [31:0] INV_TWO_VAR_RST = 32'd32768;
  localparam logic [16:0] GV_ONE          = 17'd65536;

  typedef enum logic {
    REQ_FORWARD  = 1'b0,
    REQ_BACKWARD = 1'b1
  } req_type_t;

  typedef logic [PIPE_STAGES-1:0] stage_en_t;

endpackage

`default_nettype wire

// File: rtl/gau_fwd.sv
// Forward path: g = exp(-x*x*c) as 2^(-t*log2e), table plus linear interpolation.
// Eight register stages stepped by the stage enables; depends on gau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gau_fwd import gau_pkg::*; #(
  parameter int FRAC_BITS      = FRAC_BITS_DEF,
  parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
  input  logic        clk,
  input  stage_en_t   en,
  input  logic [31:0] coef,
  input  logic [31:0] x_bits,
  output logic [31:0] value
);

  localparam int TB  = EXP_TABLE_BITS;
  localparam int TSZ = (1 << TB) + 1;
  localparam int TIW = TB + 1;
  localparam int SQW = 64 - FRAC_BITS;
  localparam int PHW = 64 - FRAC_BITS;
  localparam int TW  = FRAC_BITS + 7;
  localparam int DRW = 31 + FRAC_BITS;
  localparam int PSW = FRAC_BITS + TB;

  localparam logic [63:0] T_CAP     = 64'd64 << FRAC_BITS;
  localparam logic [63:0] LOG2E_Q30 = 64'd1549082005;
  localparam logic [63:0] HALF_Q30  = 64'd1 << 29;
  localparam logic [DRW:0] HALF_F   = {{DRW{1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic [7:0]  SH_BASE   = 8'(30 - FRAC_BITS);

  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] rem_v;
    logic [63:0] res_v;
    logic [63:0] bit_v;
    rem_v = n;
    res_v = '0;
    bit_v = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem_v >= res_v + bit_v) begin
        rem_v = rem_v - (res_v + bit_v);
        res_v = (res_v >> 1) + bit_v;
      end else begin
        res_v = res_v >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res_v;
  endfunction

  // 2^(-k/2^TB) in Q30, from repeated square roots of one half
  function automatic logic [30:0] exp_tab_entry(input int k);
    logic [63:0] root [TB+1];
    logic [63:0] v;
    root[0] = 64'd1 << 29;
    for (int m = 1; m <= TB; m++) begin
      root[m] = isqrt64(root[m-1] << 30);
    end
    v = 64'd1 << 30;
    for (int j = 0; j < TB; j++) begin
      if (((k >> j) & 1) == 1) begin
        v = (v * root[TB-j] + (64'd1 << 29)) >> 30;
      end
    end
    if (k == (1 << TB)) begin
      v = 64'd1 << 29;
    end
    return v[30:0];
  endfunction

  logic [30:0] exp_tab [TSZ];

  for (genvar k = 0; k < TSZ; k++) begin : g_tab
    assign exp_tab[k] = exp_tab_entry(k);
  end

  logic [31:0]          x_mag_r;
  logic [31:0]          x_mag_nxt;
  logic [63:0]          sqr_r;
  logic [63:0]          p_lo_r;
  logic [PHW-1:0]       p_hi_r;
  logic [TW-1:0]        t_r;
  logic [TW-1:0]        t_nxt;
  logic [TW-1:0]        u_r;
  logic [TW-1:0]        u_nxt;
  logic [30:0]          g0_r;
  logic [30:0]          g0_nxt;
  logic [30:0]          d_r;
  logic [30:0]          d_nxt;
  logic [FRAC_BITS-1:0] rem_r;
  logic [FRAC_BITS-1:0] rem_nxt;
  logic [6:0]           n_r;
  logic [6:0]           n_nxt;
  logic [DRW-1:0]       dr_r;
  logic [30:0]          g0_d_r;
  logic [6:0]           n_d_r;
  logic [31:0]          value_r;
  logic [31:0]          value_nxt;

  logic [SQW-1:0]       sq;
  logic [63:0]          tt;
  logic [63:0]          up;
  logic [PSW-1:0]       pos;
  logic [TIW-1:0]       idx;
  logic [30:0]          g1;
  logic [DRW:0]         sub_full;
  logic [30:0]          g;
  logic [7:0]           sh;
  logic [32:0]          rnd;

  assign sq = sqr_r[63:FRAC_BITS];

  always_comb begin
    x_mag_nxt = x_bits[31] ? (~x_bits + 32'd1) : x_bits;

    tt = (64'(p_hi_r) << (32 - FRAC_BITS)) + (p_lo_r >> FRAC_BITS);
    if (64'(p_hi_r) >= T_CAP || tt > T_CAP) begin
      t_nxt = T_CAP[TW-1:0];
    end else begin
      t_nxt = tt[TW-1:0];
    end

    up    = 64'(t_r) * LOG2E_Q30 + HALF_Q30;
    u_nxt = up[TW+29:30];

    n_nxt   = u_r[TW-1:FRAC_BITS];
    pos     = {u_r[FRAC_BITS-1:0], {TB{1'b0}}};
    idx     = {1'b0, pos[PSW-1:FRAC_BITS]};
    rem_nxt = pos[FRAC_BITS-1:0];
    g0_nxt  = exp_tab[idx];
    g1      = exp_tab[idx + 1'b1];
    d_nxt   = (g0_nxt >= g1) ? (g0_nxt - g1) : '0;

    sub_full = {1'b0, dr_r} + HALF_F;
    g        = g0_d_r - sub_full[FRAC_BITS+30:FRAC_BITS];
    sh       = SH_BASE + {1'b0, n_d_r};
    rnd      = {2'b00, g} + (33'd1 << (sh[4:0] - 5'd1));
    if (sh >= 8'd32) begin
      value_nxt = '0;
    end else begin
      value_nxt = 32'(rnd >> sh[4:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_mag_r <= x_mag_nxt;
    end
    if (en[1]) begin
      sqr_r <= 64'(x_mag_r) * 64'(x_mag_r);
    end
    if (en[2]) begin
      p_lo_r <= 64'(sq[31:0]) * 64'(coef);
      p_hi_r <= PHW'(sq[SQW-1:32]) * PHW'(coef);
    end
    if (en[3]) begin
      t_r <= t_nxt;
    end
    if (en[4]) begin
      u_r <= u_nxt;
    end
    if (en[5]) begin
      g0_r  <= g0_nxt;
      d_r   <= d_nxt;
      rem_r <= rem_nxt;
      n_r   <= n_nxt;
    end
    if (en[6]) begin
      dr_r   <= DRW'(d_r) * DRW'(rem_r);
      g0_d_r <= g0_r;
      n_d_r  <= n_r;
    end
    if (en[7]) begin
      value_r <= value_nxt;
    end
  end

  assign value = value_r;

endmodule

`default_nettype wire

// File: rtl/gau_bwd.sv
// Backward path: grad * x * g * (-2c), wide product from partial products,
// rounded and clipped to 32 bits. Eight register stages; depends on gau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gau_bwd import gau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  stage_en_t   en,
  input  logic [31:0] coef,
  input  logic [31:0] x_bits,
  input  logic [31:0] grad_bits,
  input  logic [16:0] gv_bits,
  output logic [31:0] value,
  output logic        sat
);

  localparam int SHR = 2 * FRAC_BITS + 15;
  localparam int RW  = 128 - SHR;

  localparam logic [64:0]   RND     = 65'd1 << (SHR - 1);
  localparam logic [RW-1:0] LIM_NEG = RW'(64'h0000_0000_8000_0000);
  localparam logic [RW-1:0] LIM_POS = RW'(64'h0000_0000_7FFF_FFFF);

  logic [31:0]   x_mag_r;
  logic [31:0]   g_mag_r;
  logic [16:0]   gv_r;
  logic [63:0]   a_r;
  logic [48:0]   b_r;
  logic [63:0]   pp00_r;
  logic [48:0]   pp01_r;
  logic [63:0]   pp10_r;
  logic [48:0]   pp11_r;
  logic [64:0]   mid_r;
  logic [64:0]   lo_r;
  logic [48:0]   hi_r;
  logic [127:0]  p_r;
  logic [31:0]   mag_r;
  logic [31:0]   mag_nxt;
  logic          sat5_r;
  logic          sat5_nxt;
  logic [31:0]   res6_r;
  logic          sat6_r;
  logic [31:0]   value_r;
  logic          sat_r;
  logic [5:0]    neg_r;
  logic          neg_nxt;

  logic [31:0]   x_mag_nxt;
  logic [31:0]   g_mag_nxt;
  logic [16:0]   gv_nxt;
  logic [RW-1:0] r;
  logic [RW-1:0] lim;

  always_comb begin
    x_mag_nxt = x_bits[31] ? (~x_bits + 32'd1) : x_bits;
    g_mag_nxt = grad_bits[31] ? (~grad_bits + 32'd1) : grad_bits;
    neg_nxt   = !(x_bits[31] ^ grad_bits[31]);
    gv_nxt    = (gv_bits > GV_ONE) ? GV_ONE : gv_bits;

    r        = p_r[127:SHR];
    lim      = neg_r[4] ? LIM_NEG : LIM_POS;
    sat5_nxt = (r > lim);
    mag_nxt  = sat5_nxt ? lim[31:0] : r[31:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_mag_r  <= x_mag_nxt;
      g_mag_r  <= g_mag_nxt;
      gv_r     <= gv_nxt;
      neg_r[0] <= neg_nxt;
    end
    if (en[1]) begin
      a_r      <= 64'(g_mag_r) * 64'(x_mag_r);
      b_r      <= 49'(gv_r) * 49'(coef);
      neg_r[1] <= neg_r[0];
    end
    if (en[2]) begin
      pp00_r   <= 64'(a_r[31:0]) * 64'(b_r[31:0]);
      pp01_r   <= 49'(a_r[31:0]) * 49'(b_r[48:32]);
      pp10_r   <= 64'(a_r[63:32]) * 64'(b_r[31:0]);
      pp11_r   <= 49'(a_r[63:32]) * 49'(b_r[48:32]);
      neg_r[2] <= neg_r[1];
    end
    if (en[3]) begin
      mid_r    <= 65'(pp01_r) + 65'(pp10_r);
      lo_r     <= 65'(pp00_r) + RND;
      hi_r     <= pp11_r;
      neg_r[3] <= neg_r[2];
    end
    if (en[4]) begin
      p_r      <= (128'(hi_r) << 64) + (128'(mid_r) << 32) + 128'(lo_r);
      neg_r[4] <= neg_r[3];
    end
    if (en[5]) begin
      mag_r    <= mag_nxt;
      sat5_r   <= sat5_nxt;
      neg_r[5] <= neg_r[4];
    end
    if (en[6]) begin
      res6_r <= neg_r[5] ? (~mag_r + 32'd1) : mag_r;
      sat6_r <= sat5_r;
    end
    if (en[7]) begin
      value_r <= res6_r;
      sat_r   <= sat6_r;
    end
  end

  assign value = value_r;
  assign sat   = sat_r;

endmodule

`default_nettype wire

// File: rtl/gaussian_activation_unit_core.sv
// Gaussian activation unit top level: handshake, stage valids, coefficient
// register and output register. Depends on gau_pkg, gau_fwd and gau_bwd.
//
// Usage:
//   Input words (in_req_type, in_x, in_gauss_value, in_upstream_grad) are taken
//   on a rising edge with in_valid high and in_stall low. in_req_type selects
//   forward value exp(-x*x*c) or backward gradient grad*x*g*(-2c).
//   Result words (out_result_value, out_saturated) leave on out_valid, held
//   while out_stall is high.
//   cfg_wr_en with cfg_wr_data writes c (unsigned Q16.16); write only when idle.
//   The path runs through eight compute stages (multipliers, exp table and
//   interpolation) and then the output register. One word per cycle sustained while out_stall is low.
//   Reset clears all stage valids and sets c to 0.5 (32768).
//   When the receiver stalls, the output register holds its word; stages
//   behind it keep moving until they fill, so bubbles close up, and in_stall
//   rises only once the first stage is full and cannot drain.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_activation_unit_core import gau_pkg::*; #(
  parameter int FRAC_BITS      = FRAC_BITS_DEF,
  parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic signed [31:0] in_x,
  input  logic        [16:0] in_gauss_value,
  input  logic signed [31:0] in_upstream_grad,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result_value,
  output logic               out_saturated,
  input  logic               cfg_wr_en,
  input  logic        [31:0] cfg_wr_data
);

  logic [31:0]            inv_two_var_r;
  logic [PIPE_STAGES-1:0] vld_r;
  logic [PIPE_STAGES-1:0] vld_nxt;
  req_type_t              req_r [PIPE_STAGES];
  logic                   out_valid_r;
  logic [31:0]            out_result_value_r;
  logic                   out_saturated_r;
  logic [PIPE_STAGES:0]   rdy;
  stage_en_t              en;
  logic [31:0]            fwd_value;
  logic [31:0]            bwd_value;
  logic                   bwd_sat;

  always_comb begin
    rdy[PIPE_STAGES] = !out_valid_r || !out_stall;
    for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[0] = in_valid;
    for (int k = 1; k < PIPE_STAGES; k++) begin
      vld_nxt[k] = vld_r[k-1];
    end
  end

  assign en       = rdy[PIPE_STAGES-1:0];
  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_two_var_r <= INV_TWO_VAR_RST;
    end else if (cfg_wr_en) begin
      inv_two_var_r <= cfg_wr_data;
    end
  end

  // advance each stage valid when the stage can take a word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int k = 0; k < PIPE_STAGES; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
      if (rdy[PIPE_STAGES]) begin
        out_valid_r <= vld_r[PIPE_STAGES-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      req_r[0] <= req_type_t'(in_req_type);
    end
    for (int k = 1; k < PIPE_STAGES; k++) begin
      if (en[k]) begin
        req_r[k] <= req_r[k-1];
      end
    end
    if (rdy[PIPE_STAGES]) begin
      if (req_r[PIPE_STAGES-1] == REQ_BACKWARD) begin
        out_result_value_r <= bwd_value;
        out_saturated_r    <= bwd_sat;
      end else begin
        out_result_value_r <= fwd_value;
        out_saturated_r    <= 1'b0;
      end
    end
  end

  gau_fwd #(
    .FRAC_BITS      (FRAC_BITS),
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_fwd (
    .clk    (clk),
    .en     (en),
    .coef   (inv_two_var_r),
    .x_bits ($unsigned(in_x)),
    .value  (fwd_value)
  );

  gau_bwd #(
    .FRAC_BITS (FRAC_BITS)
  ) u_bwd (
    .clk       (clk),
    .en        (en),
    .coef      (inv_two_var_r),
    .x_bits    ($unsigned(in_x)),
    .grad_bits ($unsigned(in_upstream_grad)),
    .gv_bits   (in_gauss_value),
    .value     (bwd_value),
    .sat       (bwd_sat)
  );

  assign out_valid        = out_valid_r;
  assign out_result_value = $signed(out_result_value_r);
  assign out_saturated    = out_saturated_r;

endmodule

`default_nettype wire

// File: verif/gaussian_activation_unit_core_tb.sv
// Self-checking testbench for gaussian_activation_unit_core: forward and backward words
// at random handshake rates, checked against a bit-exact predictor in this file.
// Depends on gau_pkg and the RTL of gaussian_activation_unit_core only.
`timescale 1ns / 1ps

module gaussian_activation_unit_core_tb;
  import gau_pkg::*;

  localparam int FRAC         = FRAC_BITS_DEF;
  localparam int EXP_TBL_BITS = EXP_TABLE_BITS_DEF;
  localparam int TBL_N        = 1 << EXP_TBL_BITS;
  localparam int BWD_SHIFT    = 2 * FRAC + 15;
  localparam int DRAIN_CYCLES = PIPE_STAGES + 5;

  localparam logic [63:0] ONE_Q30   = 64'd1 << 30;
  localparam logic [63:0] LOG2E_Q30 = 64'd1549082005;
  localparam logic [63:0] T_CAP     = 64'd64 << FRAC;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
  } act_word_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_req_type;
  logic signed [31:0] in_x;
  logic        [16:0] in_gauss_value;
  logic signed [31:0] in_upstream_grad;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_result_value;
  logic               out_saturated;
  logic               cfg_wr_en;
  logic        [31:0] cfg_wr_data;

  logic [63:0] exp_frac_tab [0:TBL_N];
  logic [31:0] coeff_model;
  act_word_t   pending_act_words [$];

  int err_count;
  int checked_count;
  int fwd_count;
  int bwd_count;
  int sat_count;
  int coeff_writes;
  int rx_hold_off;
  bit tx_no_idle;
  bit rx_no_idle;

  gaussian_activation_unit_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_x             (in_x),
    .in_gauss_value   (in_gauss_value),
    .in_upstream_grad (in_upstream_grad),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_saturated    (out_saturated),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [63:0] isqrt_u64(input logic [63:0] n_in);
    logic [63:0] rem_v;
    logic [63:0] res;
    logic [63:0] bit_v;
    rem_v = n_in;
    res   = 64'd0;
    bit_v = 64'd1 << 62;
    while (bit_v > rem_v) bit_v = bit_v >> 2;
    while (bit_v != 64'd0) begin
      if (rem_v >= res + bit_v) begin
        rem_v = rem_v - (res + bit_v);
        res   = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // 2^(-k/TBL_N) in Q30, products of successive square roots of one half
  function automatic void build_exp_table();
    logic [63:0] root [0:EXP_TBL_BITS];
    logic [63:0] v;
    root[0] = ONE_Q30 >> 1;
    for (int m = 1; m <= EXP_TBL_BITS; m++) root[m] = isqrt_u64(root[m-1] << 30);
    for (int k = 0; k < TBL_N; k++) begin
      v = ONE_Q30;
      for (int j = 0; j < EXP_TBL_BITS; j++)
        if (k[j]) v = (v * root[EXP_TBL_BITS-j] + (ONE_Q30 >> 1)) >> 30;
      exp_frac_tab[k] = v;
    end
    exp_frac_tab[TBL_N] = ONE_Q30 >> 1;
  endfunction

  function automatic logic [63:0] abs_q16(input logic [31:0] v);
    logic [31:0] m;
    m = v[31] ? -v : v;
    return {32'd0, m};
  endfunction

  function automatic logic [31:0] gauss_fwd_value(input logic [63:0] mag_x,
                                                  input logic [31:0] coeff);
    logic [127:0] sq;
    logic [127:0] t;
    logic [63:0]  u, n, f, pos, idx, rem_f, g, d, s;
    sq = ({64'd0, mag_x} * {64'd0, mag_x}) >> FRAC;
    t  = (sq * {96'd0, coeff}) >> FRAC;
    if (t > {64'd0, T_CAP}) t = {64'd0, T_CAP};
    u     = (t[63:0] * LOG2E_Q30 + (ONE_Q30 >> 1)) >> 30;
    n     = u >> FRAC;
    f     = u & ((64'd1 << FRAC) - 64'd1);
    pos   = f << EXP_TBL_BITS;
    idx   = (pos >> FRAC) & (TBL_N - 1);
    rem_f = pos & ((64'd1 << FRAC) - 64'd1);
    g     = exp_frac_tab[idx];
    if (exp_frac_tab[idx] >= exp_frac_tab[idx+1]) begin
      d = exp_frac_tab[idx] - exp_frac_tab[idx+1];
      g = g - ((d * rem_f + (64'd1 << (FRAC - 1))) >> FRAC);
    end
    s = 64'(30 - FRAC) + n;
    if (s >= 64'd32) return 32'd0;
    return 32'((g + (64'd1 << (s - 64'd1))) >> s);
  endfunction

  function automatic act_word_t gauss_bwd_grad(input logic [31:0] x, input logic [31:0] grad,
                                               input logic [16:0] gv_in,
                                               input logic [31:0] coeff);
    act_word_t    w;
    logic [127:0] prod;
    logic [127:0] mag;
    logic [63:0]  gv;
    logic [63:0]  lim;
    logic         neg;
    gv   = (gv_in > GV_ONE) ? {47'd0, GV_ONE} : {47'd0, gv_in};
    prod = {64'd0, abs_q16(grad) * abs_q16(x)} * {64'd0, gv * {32'd0, coeff}};
    mag  = (prod + (128'd1 << (BWD_SHIFT - 1))) >> BWD_SHIFT;
    // the minus folds into the sign, the factor two into BWD_SHIFT
    neg  = ~(x[31] ^ grad[31]);
    lim  = neg ? (64'd1 << 31) : ((64'd1 << 31) - 64'd1);
    w.sat = 1'b0;
    if (mag > {64'd0, lim}) begin
      mag   = {64'd0, lim};
      w.sat = 1'b1;
    end
    w.value = neg ? -mag[31:0] : mag[31:0];
    return w;
  endfunction

  function automatic act_word_t predict_activation(input logic rt, input logic [31:0] x,
                                                   input logic [16:0] gv,
                                                   input logic [31:0] grad);
    act_word_t w;
    if (rt == REQ_FORWARD) begin
      w.value = gauss_fwd_value(abs_q16(x), coeff_model);
      w.sat   = 1'b0;
    end else begin
      w = gauss_bwd_grad(x, grad, gv, coeff_model);
    end
    return w;
  endfunction

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin : act_monitor
    act_word_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pending_act_words.push_back(
          predict_activation(in_req_type, in_x, in_gauss_value, in_upstream_grad));
        if (in_req_type == REQ_BACKWARD) bwd_count++;
        else fwd_count++;
      end
      if (out_valid && !out_stall) begin
        if (pending_act_words.size() == 0) begin
          $error("result word with none expected: result_value=%h saturated=%b",
                 out_result_value, out_saturated);
          err_count++;
        end else begin
          want = pending_act_words.pop_front();
          if (out_result_value !== want.value) begin
            $error("result_value: expected %h, actual %h", want.value, out_result_value);
            err_count++;
          end
          if (out_saturated !== want.sat) begin
            $error("saturated: expected %b, actual %b", want.sat, out_saturated);
            err_count++;
          end
          if (want.sat) sat_count++;
          checked_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  initial begin : rx_ctrl
    int hold;
    hold      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_off > 0) begin
        out_stall <= 1'b1;
        rx_hold_off--;
      end else if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
        if (out_valid) hold = rx_no_idle ? 0 : $urandom_range(0, 4);
      end
    end
  end

  // ---------------------------------------------------------------- sender

  task automatic send_word(input req_type_t rt, input logic [31:0] x,
                           input logic [16:0] gv, input logic [31:0] grad);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= rt;
    in_x             <= x;
    in_gauss_value   <= gv;
    in_upstream_grad <= grad;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [31:0] rand_q16();
    int unsigned w;
    logic [31:0] v;
    w = $urandom_range(0, 32);
    v = $urandom;
    if (w < 32) v = v & ((32'd1 << w) - 32'd1);
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  function automatic logic [16:0] rand_gauss();
    if ($urandom_range(0, 9) < 8) return 17'($urandom_range(0, 65536));
    return 17'($urandom_range(0, 131071));
  endfunction

  function automatic logic [31:0] rand_coeff();
    logic [31:0] c;
    c = $urandom;
    if ($urandom_range(0, 7) != 0) c = c & ((32'd1 << $urandom_range(4, 24)) - 32'd1);
    return c;
  endfunction

  task automatic send_random_word();
    send_word($urandom_range(0, 1) ? REQ_BACKWARD : REQ_FORWARD, rand_q16(), rand_gauss(),
              rand_q16());
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_act_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_coeff(input logic [31:0] val);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    coeff_model = val;
    coeff_writes++;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_forward_extremes();
    send_word(REQ_FORWARD, 32'h0000_0000, 17'd0, 32'h0000_0000);
    send_word(REQ_FORWARD, 32'h0000_0001, 17'h1FFFF, 32'hFFFF_FFFF);
    send_word(REQ_FORWARD, 32'hFFFF_FFFF, 17'd65536, 32'h8000_0000);
    send_word(REQ_FORWARD, 32'h0001_0000, 17'd12345, 32'h7FFF_FFFF);
    send_word(REQ_FORWARD, 32'hFFFF_0000, 17'd0, 32'h0001_0000);
    send_word(REQ_FORWARD, 32'h0000_8000, 17'd0, 32'h0000_0000);
    send_word(REQ_FORWARD, 32'h000B_0000, 17'd0, 32'h0000_0000);
    send_word(REQ_FORWARD, 32'h7FFF_FFFF, 17'd0, 32'h0000_0000);
    send_word(REQ_FORWARD, 32'h8000_0000, 17'd0, 32'h0000_0000);
  endtask

  task automatic test_backward_corners();
    send_word(REQ_BACKWARD, 32'h0001_0000, 17'd65536, 32'h0001_0000);
    send_word(REQ_BACKWARD, 32'hFFFF_0000, 17'd40000, 32'h0001_0000);
    send_word(REQ_BACKWARD, 32'h0001_0000, 17'd40000, 32'hFFFF_0000);
    send_word(REQ_BACKWARD, 32'hFFFF_0000, 17'd40000, 32'hFFFF_0000);
    send_word(REQ_BACKWARD, 32'h7FFF_FFFF, 17'd65536, 32'h7FFF_FFFF);
    send_word(REQ_BACKWARD, 32'h8000_0000, 17'd65536, 32'h7FFF_FFFF);
    send_word(REQ_BACKWARD, 32'h8000_0000, 17'd65536, 32'h8000_0000);
    send_word(REQ_BACKWARD, 32'h0003_0000, 17'd0, 32'h0002_0000);
    send_word(REQ_BACKWARD, 32'h0001_0000, 17'h1FFFF, 32'h0001_0000);
    send_word(REQ_BACKWARD, 32'h0001_0000, 17'd65537, 32'hFFFF_8000);
    send_word(REQ_BACKWARD, 32'h0000_0000, 17'd65536, 32'h7FFF_FFFF);
    send_word(REQ_BACKWARD, 32'h0000_0001, 17'd1, 32'h0000_0001);
  endtask

  task automatic test_coeff_sweep();
    logic [31:0] coeff_set [6];
    coeff_set = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000,
                  32'h0001_8000, rand_coeff()};
    foreach (coeff_set[i]) begin
      wait_drained();
      write_coeff(coeff_set[i]);
      send_word(REQ_FORWARD, rand_q16(), rand_gauss(), rand_q16());
      send_word(REQ_BACKWARD, 32'h0001_0000, 17'd65536, 32'h0001_0000);
      repeat (38) send_random_word();
    end
  endtask

  task automatic test_random_traffic();
    for (int blk = 0; blk < 8; blk++) begin
      wait_drained();
      write_coeff(rand_coeff());
      tx_no_idle = (blk % 4 == 1) || (blk % 4 == 3);
      rx_no_idle = (blk % 4 == 2) || (blk % 4 == 3);
      repeat (200) send_random_word();
    end
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  task automatic test_output_backpressure();
    wait_drained();
    write_coeff(INV_TWO_VAR_RST);
    @(posedge clk);
    // hold the output long enough for the pipeline to fill and stall the input
    rx_hold_off = 3 * PIPE_STAGES + 20;
    tx_no_idle  = 1'b1;
    repeat (48) send_random_word();
    tx_no_idle  = 1'b0;
  endtask

  initial begin : stimulus
    in_valid         = 1'b0;
    in_req_type      = REQ_FORWARD;
    in_x             = '0;
    in_gauss_value   = '0;
    in_upstream_grad = '0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    err_count        = 0;
    checked_count    = 0;
    fwd_count        = 0;
    bwd_count        = 0;
    sat_count        = 0;
    coeff_writes     = 0;
    rx_hold_off      = 0;
    tx_no_idle       = 1'b0;
    rx_no_idle       = 1'b0;
    coeff_model      = INV_TWO_VAR_RST;
    build_exp_table();
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_forward_extremes();
    test_backward_corners();
    test_coeff_sweep();
    test_random_traffic();
    test_output_backpressure();
    wait_drained();

    $display("Checked %0d result words: %0d forward, %0d backward, %0d saturated.",
             checked_count, fwd_count, bwd_count, sat_count);
    $display("Coefficient written %0d times, zero and all-ones included, with long output hold.",
             coeff_writes);
    if (err_count == 0) begin
      $display("gaussian_activation_unit_core test passed");
    end else begin
      $display("gaussian_activation_unit_core test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("gaussian_activation_unit_core test failed");
    $finish;
  end

endmodule
